// ----- hdl/tfpp_pkg.sv -----
// Shared types, widths and helpers of the tilted face point projection.
package tfpp_pkg;

  // Axis datapath widths
  localparam int COORD_W  = 22;  // u or v after the tilt shift, Q.6
  localparam int DEN_W    = 17;  // clamped perspective denominator, Q.6
  localparam int DIST_W   = 18;  // distance to a side wall, Q.6, signed
  localparam int O_W      = 38;  // orthographic offset, Q.18
  localparam int DVD_W    = 53;  // magnitude of the perspective dividend
  localparam int QUO_W    = 40;  // quotient bits below the saturation limit
  localparam int REM_W    = 18;  // divider remainder, same width as 2*den
  localparam int P_W      = 41;  // perspective offset, saturated to +-2^40
  localparam int D3_BITS  = 8;   // dividend bits per divide-by-3 stage
  localparam int D3_STAGES = 7;
  localparam int D3_W     = D3_BITS * D3_STAGES;
  localparam int D3_MAG_W = 51;  // magnitude bits fed to the divide-by-3

  // Pipeline depths
  localparam int FRONT_LAT = 5;
  localparam int AXIS_LAT  = 3 + QUO_W + 3 + D3_STAGES + 2;
  localparam int TOTAL_LAT = FRONT_LAT + AXIS_LAT;

  // Viewing faces
  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_BACK   = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  // Register indexes
  localparam logic [2:0] CFG_HALF_W   = 3'd0;
  localparam logic [2:0] CFG_HALF_H   = 3'd1;
  localparam logic [2:0] CFG_HALF_D   = 3'd2;
  localparam logic [2:0] CFG_CENTER_X = 3'd3;
  localparam logic [2:0] CFG_CENTER_Y = 3'd4;
  localparam logic [2:0] CFG_SCALE    = 3'd5;

  // Register reset values
  localparam logic [9:0]  RST_HALF_W   = 10'd64;
  localparam logic [9:0]  RST_HALF_H   = 10'd48;
  localparam logic [9:0]  RST_HALF_D   = 10'd48;
  localparam logic [11:0] RST_CENTER_X = 12'd160;
  localparam logic [11:0] RST_CENTER_Y = 12'd120;
  localparam logic [15:0] RST_SCALE    = 16'd4096;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [2:0]         view_face;
    logic signed [15:0] tilt_about_x;
    logic signed [15:0] tilt_about_y;
  } point_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] view_depth;
    logic               behind_eye;
  } result_t;

  // Saturate to a signed 16-bit output
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/tfpp_axis.sv -----
// One screen axis: scaling, pipelined perspective divide, wall blend, rounding.
module tfpp_axis
  import tfpp_pkg::*;
(
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] coord,
  input  logic [DEN_W-1:0]          den,
  input  logic signed [DIST_W-1:0]  wall_dist,
  input  logic [15:0]               scale,
  input  logic [11:0]               center,
  output logic signed [15:0]        pos
);

  typedef struct packed {
    logic [REM_W-1:0]        rem;
    logic [QUO_W-1:0]        dvd;
    logic [QUO_W-1:0]        quo;
    logic [REM_W-1:0]        d2;
    logic                    neg;
    logic                    sat;
    logic signed [O_W-1:0]   o;
    logic signed [DIST_W-1:0] wall_dist;
  } div_st_t;

  typedef struct packed {
    logic [1:0]            rem;
    logic [D3_W-1:0]       dvd;
    logic [D3_W-1:0]       quo;
    logic                  neg;
    logic signed [P_W-1:0] p;
    logic                  blend_on;
  } d3_st_t;

  // Stage A0: orthographic offset
  logic signed [O_W-1:0]    a0_o;
  logic [DEN_W-1:0]         a0_den;
  logic signed [DIST_W-1:0] a0_dist;
  logic signed [16:0]       scale_s;

  assign scale_s = $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    a0_o    <= coord * scale_s;
    a0_den  <= den;
    a0_dist <= wall_dist;
  end

  // Stage A1: dividend 2*o*14080 + den, folded to a magnitude
  logic signed [51:0]       a1_n;
  logic signed [53:0]       a1_nn;
  logic [DVD_W-1:0]         a1_a;
  logic                     a1_neg;
  logic [REM_W-1:0]         a1_d2;
  logic signed [O_W-1:0]    a1_o;
  logic signed [DIST_W-1:0] a1_dist;

  assign a1_n  = (52'(a0_o) <<< 14) - (52'(a0_o) <<< 11) - (52'(a0_o) <<< 8);
  assign a1_nn = (54'(a1_n) <<< 1) + 54'($signed({1'b0, a0_den}));

  always_ff @(posedge clk) begin
    a1_neg  <= a1_nn[53];
    a1_a    <= a1_nn[DVD_W-1:0] ^ {DVD_W{a1_nn[53]}};
    a1_d2   <= {a0_den, 1'b0};
    a1_o    <= a0_o;
    a1_dist <= a0_dist;
  end

  // Stage A2: saturation check and first remainder
  div_st_t          div_q [0:QUO_W];
  logic [REM_W-1:0] a2_head;
  logic             a2_sat;

  assign a2_head = REM_W'(a1_a[DVD_W-1:QUO_W]);
  assign a2_sat  = (a2_head >= a1_d2);

  always_ff @(posedge clk) begin
    div_q[0].rem       <= a2_sat ? '0 : a2_head;
    div_q[0].dvd       <= a1_a[QUO_W-1:0];
    div_q[0].quo       <= '0;
    div_q[0].d2        <= a1_d2;
    div_q[0].neg       <= a1_neg;
    div_q[0].sat       <= a2_sat;
    div_q[0].o         <= a1_o;
    div_q[0].wall_dist <= a1_dist;
  end

  // Restoring divider, one quotient bit per stage
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    logic [REM_W:0] trial;
    logic           ge;

    assign trial = {div_q[i].rem, div_q[i].dvd[QUO_W-1]};
    assign ge    = (trial >= {1'b0, div_q[i].d2});

    always_ff @(posedge clk) begin
      div_q[i+1]     <= div_q[i];
      div_q[i+1].rem <= ge ? REM_W'(trial - {1'b0, div_q[i].d2}) : trial[REM_W-1:0];
      div_q[i+1].dvd <= {div_q[i].dvd[QUO_W-2:0], 1'b0};
      div_q[i+1].quo <= {div_q[i].quo[QUO_W-2:0], ge};
    end
  end

  // Stage P: signed, saturated perspective offset
  logic signed [P_W-1:0]    p_p;
  logic signed [O_W-1:0]    p_o;
  logic signed [DIST_W-1:0] p_dist;
  logic [QUO_W-1:0]         p_qs;

  assign p_qs = div_q[QUO_W].sat ? '1 : div_q[QUO_W].quo;

  always_ff @(posedge clk) begin
    p_p    <= $signed({1'b0, p_qs} ^ {P_W{div_q[QUO_W].neg}});
    p_o    <= div_q[QUO_W].o;
    p_dist <= div_q[QUO_W].wall_dist;
  end

  // Stage B1: blend weight and split product (o - p) * k
  logic signed [41:0] b1_e;
  logic               b1_on;
  logic signed [18:0] b1_kk;
  logic [15:0]        b1_k;
  logic signed [16:0] b1_ks;
  logic signed [20:0] b1_ehi;
  logic [20:0]        b1_elo;
  logic signed [37:0] b1_ph;
  logic [36:0]        b1_pl;
  logic signed [P_W-1:0] b1_p;
  logic               b1_use;

  assign b1_e   = 42'(p_o) - 42'(p_p);
  assign b1_on  = (p_dist < 18'sd768);
  assign b1_kk  = 19'sd768 - 19'(p_dist);
  assign b1_k   = b1_on ? b1_kk[15:0] : 16'd0;
  assign b1_ks  = $signed({1'b0, b1_k});
  assign b1_ehi = b1_e[41:21];
  assign b1_elo = b1_e[20:0];

  always_ff @(posedge clk) begin
    b1_ph  <= b1_ehi * b1_ks;
    b1_pl  <= 37'(b1_elo) * 37'(b1_k);
    b1_p   <= p_p;
    b1_use <= b1_on;
  end

  // Stage B2: sum partial products, round bias, divide by 256, fold sign
  d3_st_t             d3_q [0:D3_STAGES];
  logic signed [59:0] b2_sum;
  logic [51:0]        b2_t;

  assign b2_sum = (60'(b1_ph) <<< 21) + $signed(60'(b1_pl)) + 60'sd384;
  assign b2_t   = b2_sum[59:8];

  always_ff @(posedge clk) begin
    d3_q[0].rem      <= 2'd0;
    d3_q[0].dvd      <= D3_W'(b2_t[D3_MAG_W-1:0] ^ {D3_MAG_W{b2_t[51]}});
    d3_q[0].quo      <= '0;
    d3_q[0].neg      <= b2_t[51];
    d3_q[0].p        <= b1_p;
    d3_q[0].blend_on <= b1_use;
  end

  // Divide by 3, eight dividend bits per stage
  for (genvar s = 0; s < D3_STAGES; s++) begin : g_d3
    logic [1:0]         rem_n;
    logic [D3_BITS-1:0] qb;

    always_comb begin
      logic [2:0] cur;
      rem_n = d3_q[s].rem;
      qb    = '0;
      for (int j = 0; j < D3_BITS; j++) begin
        cur = {rem_n, d3_q[s].dvd[D3_W-1-j]};
        if (cur >= 3'd3) begin
          qb[D3_BITS-1-j] = 1'b1;
          rem_n = 2'(cur - 3'd3);
        end else begin
          rem_n = cur[1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      d3_q[s+1]     <= d3_q[s];
      d3_q[s+1].rem <= rem_n;
      d3_q[s+1].dvd <= {d3_q[s].dvd[D3_W-D3_BITS-1:0], {D3_BITS{1'b0}}};
      d3_q[s+1].quo <= {d3_q[s].quo[D3_W-D3_BITS-1:0], qb};
    end
  end

  // Stage C1: center + perspective + blend correction
  logic signed [50:0] c1_blend;
  logic signed [52:0] c1_acc;
  logic signed [52:0] c1_sum;

  assign c1_blend = $signed({1'b0, d3_q[D3_STAGES].quo[49:0]} ^ {51{d3_q[D3_STAGES].neg}});
  assign c1_sum   = $signed(53'({center, 18'd0})) + 53'(d3_q[D3_STAGES].p)
                  + (d3_q[D3_STAGES].blend_on ? 53'(c1_blend) : 53'sd0);

  always_ff @(posedge clk) begin
    c1_acc <= c1_sum;
  end

  // Stage C2: round to Q.4 and saturate
  logic signed [52:0] c2_r;
  logic signed [38:0] c2_q;

  assign c2_r = c1_acc + 53'sd8192;
  assign c2_q = $signed(c2_r[52:14]);

  always_ff @(posedge clk) begin
    pos <= sat16(40'(c2_q));
  end

endmodule

// ----- hdl/tilted_face_point_projection.sv -----
// Top level of the tilted face point projection pipeline.
//
// Usage: drive point with one transaction and pulse start; busy is always low,
// so a new point may be given in every cycle. The config port (cfg_we,
// cfg_index, cfg_data) writes one register per cycle with no wait state and
// must only be used while no point is in flight.
// Each accepted point gives its result on result with done high.
// Throughput: one point per cycle. The pipeline depth comes from the 40-stage
// restoring divider (one quotient bit per stage) for the perspective divide,
// followed by a 7-stage divide-by-3 for the wall blend.
// Reset clears all pipeline valid bits, drops any point in flight and loads the
// register reset values. Results are presented for exactly one cycle each;
// the receiver has no way to stall the pipeline.
module tilted_face_point_projection
  import tfpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  point_t      point,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    logic               valid;
    logic signed [15:0] depth;
    logic               behind;
  } side_t;

  // Configuration registers
  logic [9:0]  half_w;
  logic [9:0]  half_h;
  logic [9:0]  half_d;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [15:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_w   <= RST_HALF_W;
      half_h   <= RST_HALF_H;
      half_d   <= RST_HALF_D;
      center_x <= RST_CENTER_X;
      center_y <= RST_CENTER_Y;
      scale    <= RST_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_W:   half_w   <= cfg_data[9:0];
        CFG_HALF_H:   half_h   <= cfg_data[9:0];
        CFG_HALF_D:   half_d   <= cfg_data[9:0];
        CFG_CENTER_X: center_x <= cfg_data[11:0];
        CFG_CENTER_Y: center_y <= cfg_data[11:0];
        CFG_SCALE:    scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage S1: face selection and wall distances
  logic signed [17:0] wall_w, wall_h, wall_d;
  logic signed [16:0] px, py, pz, ax, ay;
  logic signed [16:0] u_sel, v_sel;
  logic signed [17:0] depth_sel;

  assign wall_w = $signed({2'b0, half_w, 6'd0});
  assign wall_h = $signed({2'b0, half_h, 6'd0});
  assign wall_d = $signed({2'b0, half_d, 6'd0});
  assign px = 17'(point.point_x);
  assign py = 17'(point.point_y);
  assign pz = 17'(point.point_z);
  assign ax = px[16] ? -px : px;
  assign ay = py[16] ? -py : py;

  always_comb begin
    u_sel = '0;
    v_sel = '0;
    depth_sel = '0;
    unique case (point.view_face)
      FACE_FRONT: begin
        u_sel = px;  v_sel = py;  depth_sel = wall_d - 18'(pz);
      end
      FACE_BACK: begin
        u_sel = -px; v_sel = py;  depth_sel = 18'(pz) + wall_d;
      end
      FACE_LEFT: begin
        u_sel = pz;  v_sel = py;  depth_sel = 18'(px) + wall_w;
      end
      FACE_RIGHT: begin
        u_sel = -pz; v_sel = py;  depth_sel = wall_w - 18'(px);
      end
      FACE_TOP: begin
        u_sel = px;  v_sel = -pz; depth_sel = wall_d - 18'(py);
      end
      FACE_BOTTOM: begin
        u_sel = px;  v_sel = pz;  depth_sel = 18'(py) + wall_h;
      end
      default: ;
    endcase
  end

  logic               s1_valid;
  logic signed [16:0] s1_u, s1_v;
  logic signed [17:0] s1_depth;
  logic signed [17:0] s1_dist_x, s1_dist_y;
  logic signed [15:0] s1_tx, s1_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_u      <= u_sel;
    s1_v      <= v_sel;
    s1_depth  <= depth_sel;
    s1_dist_x <= wall_w - 18'(ax);
    s1_dist_y <= wall_h - 18'(ay);
    s1_tx     <= point.tilt_about_x;
    s1_ty     <= point.tilt_about_y;
  end

  // Stage S2: depth * tilt, perspective denominator
  logic signed [17:0] den_raw;
  logic               den_behind;
  logic signed [33:0] prod_u, prod_v;

  assign den_raw    = 18'sd14080 + s1_depth;
  assign den_behind = den_raw[17] || (den_raw == 18'sd0);
  assign prod_u     = s1_depth * s1_ty;
  assign prod_v     = s1_depth * s1_tx;

  logic               s2_valid;
  logic signed [33:0] s2_prod_u, s2_prod_v;
  logic signed [16:0] s2_u, s2_v;
  logic signed [17:0] s2_dist_x, s2_dist_y;
  logic [DEN_W-1:0]   s2_den;
  logic               s2_behind;
  logic signed [15:0] s2_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_prod_u <= prod_u;
    s2_prod_v <= prod_v;
    s2_u      <= s1_u;
    s2_v      <= s1_v;
    s2_dist_x <= s1_dist_x;
    s2_dist_y <= s1_dist_y;
    s2_den    <= den_behind ? DEN_W'(1) : den_raw[DEN_W-1:0];
    s2_behind <= den_behind;
    s2_depth  <= sat16(40'(s1_depth));
  end

  // Stage S3: times 7/16384 with round bias, offset for the divide by 5
  logic signed [37:0] m_u, m_v;

  assign m_u = (38'(s2_prod_u) <<< 3) - 38'(s2_prod_u) + 38'sd40960;
  assign m_v = (38'(s2_prod_v) <<< 3) - 38'(s2_prod_v) + 38'sd40960;

  logic               s3_valid;
  logic [23:0]        s3_a_u, s3_a_v;
  logic signed [16:0] s3_u, s3_v;
  logic signed [17:0] s3_dist_x, s3_dist_y;
  logic [DEN_W-1:0]   s3_den;
  logic               s3_behind;
  logic signed [15:0] s3_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_a_u    <= m_u[37:14] + 24'd10485760;
    s3_a_v    <= m_v[37:14] + 24'd10485760;
    s3_u      <= s2_u;
    s3_v      <= s2_v;
    s3_dist_x <= s2_dist_x;
    s3_dist_y <= s2_dist_y;
    s3_den    <= s2_den;
    s3_behind <= s2_behind;
    s3_depth  <= s2_depth;
  end

  // Stage S4: floor divide by 5 through the reciprocal, remove offset
  logic [48:0] r_u, r_v;

  assign r_u = 49'(s3_a_u) * 49'd26843546;
  assign r_v = 49'(s3_a_v) * 49'd26843546;

  logic               s4_valid;
  logic signed [22:0] s4_tilt_u, s4_tilt_v;
  logic signed [16:0] s4_u, s4_v;
  logic signed [17:0] s4_dist_x, s4_dist_y;
  logic [DEN_W-1:0]   s4_den;
  logic               s4_behind;
  logic signed [15:0] s4_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_tilt_u <= $signed({1'b0, r_u[48:27]} - 23'd2097152);
    s4_tilt_v <= $signed({1'b0, r_v[48:27]} - 23'd2097152);
    s4_u      <= s3_u;
    s4_v      <= s3_v;
    s4_dist_x <= s3_dist_x;
    s4_dist_y <= s3_dist_y;
    s4_den    <= s3_den;
    s4_behind <= s3_behind;
    s4_depth  <= s3_depth;
  end

  // Stage S5: apply the tilt shift
  logic                      s5_valid;
  logic signed [COORD_W-1:0] s5_u, s5_v;
  logic signed [17:0]        s5_dist_x, s5_dist_y;
  logic [DEN_W-1:0]          s5_den;
  logic                      s5_behind;
  logic signed [15:0]        s5_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_u      <= COORD_W'(s4_u) + COORD_W'(s4_tilt_u);
    s5_v      <= COORD_W'(s4_v) - COORD_W'(s4_tilt_v);
    s5_dist_x <= s4_dist_x;
    s5_dist_y <= s4_dist_y;
    s5_den    <= s4_den;
    s5_behind <= s4_behind;
    s5_depth  <= s4_depth;
  end

  // Per-axis projection
  logic signed [15:0] pos_x, pos_y;

  tfpp_axis u_axis_x (
    .clk       (clk),
    .coord     (s5_u),
    .den       (s5_den),
    .wall_dist (s5_dist_x),
    .scale     (scale),
    .center    (center_x),
    .pos       (pos_x)
  );

  tfpp_axis u_axis_y (
    .clk       (clk),
    .coord     (s5_v),
    .den       (s5_den),
    .wall_dist (s5_dist_y),
    .scale     (scale),
    .center    (center_y),
    .pos       (pos_y)
  );

  // Valid, depth and flag ride alongside the axis pipelines
  side_t side_q [0:AXIS_LAT-1];

  always_ff @(posedge clk) begin
    side_q[0].depth  <= s5_depth;
    side_q[0].behind <= s5_behind;
    for (int i = 1; i < AXIS_LAT; i++) begin
      side_q[i].depth  <= side_q[i-1].depth;
      side_q[i].behind <= side_q[i-1].behind;
    end
    if (rst) begin
      for (int i = 0; i < AXIS_LAT; i++) begin
        side_q[i].valid <= 1'b0;
      end
    end else begin
      side_q[0].valid <= s5_valid;
      for (int i = 1; i < AXIS_LAT; i++) begin
        side_q[i].valid <= side_q[i-1].valid;
      end
    end
  end

  assign done              = side_q[AXIS_LAT-1].valid;
  assign result.screen_x   = pos_x;
  assign result.screen_y   = pos_y;
  assign result.view_depth = side_q[AXIS_LAT-1].depth;
  assign result.behind_eye = side_q[AXIS_LAT-1].behind;

  // Every accepted transaction comes out after the full pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("result strobe missing at pipeline latency");

  // Behind-eye flag must agree with the reported depth
  a_behind: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.behind_eye == ($signed(result.view_depth) <= -16'sd14080)))
    else $error("behind_eye disagrees with view_depth");

  // Reset flushes the pipeline
  a_flush: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

// ----- sim/tilted_face_point_projection_tb.sv -----
// Self-checking testbench for the tilted face point projection pipeline.
module tilted_face_point_projection_tb
  import tfpp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 400;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  point_t      point;
  logic        done;
  result_t     result;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Shadow copy of the configuration registers
  logic [9:0]  half_w;
  logic [9:0]  half_h;
  logic [9:0]  half_d;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [15:0] scale;

  result_t projected_q[$];
  result_t want;
  int      errors;
  int      points_sent;
  int      points_checked;
  int      behind_seen;
  int      cfg_sets;
  int      quiet_cycles;

  tilted_face_point_projection i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .point     (point),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Fixed-point helpers of the projection
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint round_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Screen position on one axis, with the wall blend
  function automatic longint screen_pos(longint center, longint o, longint p,
                                        longint half, longint coord);
    longint wall_gap;
    longint acc;
    wall_gap = half * 64 - ((coord < 0) ? -coord : coord);
    acc = center * (longint'(1) << 18) + p;
    if (wall_gap < 768) acc = acc + round_quot((o - p) * (768 - wall_gap), 768);
    return round_quot(acc, longint'(1) << 14);
  endfunction

  function automatic result_t project(point_t pt);
    result_t r;
    longint x, y, z, tx, ty, u, v, depth, den, ou, ov, pu, pv;
    logic behind;
    x = pt.point_x;
    y = pt.point_y;
    z = pt.point_z;
    tx = pt.tilt_about_x;
    ty = pt.tilt_about_y;
    u = 0;
    v = 0;
    depth = 0;
    case (pt.view_face)
      FACE_FRONT:  begin u = x;  v = y;  depth = half_d * 64 - z; end
      FACE_BACK:   begin u = -x; v = y;  depth = z + half_d * 64; end
      FACE_LEFT:   begin u = z;  v = y;  depth = x + half_w * 64; end
      FACE_RIGHT:  begin u = -z; v = y;  depth = half_w * 64 - x; end
      FACE_TOP:    begin u = x;  v = -z; depth = half_d * 64 - y; end
      FACE_BOTTOM: begin u = x;  v = z;  depth = y + half_h * 64; end
      default: ;
    endcase
    u = u + round_quot(depth * ty * 7, 5 * 16384);
    v = v - round_quot(depth * tx * 7, 5 * 16384);
    den = 14080 + depth;
    behind = (den <= 0);
    if (behind) den = 1;
    ou = u * longint'(scale);
    ov = v * longint'(scale);
    pu = clip(round_quot(ou * 14080, den), longint'(1) << 40);
    pv = clip(round_quot(ov * 14080, den), longint'(1) << 40);
    r.screen_x   = 16'(clip(screen_pos(center_x, ou, pu, half_w, x), 32768));
    r.screen_y   = 16'(clip(screen_pos(center_y, ov, pv, half_h, y), 32768));
    r.view_depth = 16'(clip(depth, 32768));
    r.behind_eye = behind;
    return r;
  endfunction

  task automatic report(string what, longint got, longint exp);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, exp,
             points_checked);
  endtask

  // Record accepted transactions, check results, watch for a stall
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) begin
        projected_q.push_back(project(point));
        points_sent++;
      end
      if (done) begin
        if (projected_q.size() == 0) begin
          report("unexpected result", result.screen_x, 0);
        end else begin
          want = projected_q.pop_front();
          if (result.screen_x !== want.screen_x)
            report("screen_x", result.screen_x, want.screen_x);
          if (result.screen_y !== want.screen_y)
            report("screen_y", result.screen_y, want.screen_y);
          if (result.view_depth !== want.view_depth)
            report("view_depth", result.view_depth, want.view_depth);
          if (result.behind_eye !== want.behind_eye)
            report("behind_eye", result.behind_eye, want.behind_eye);
          if (want.behind_eye) behind_seen++;
        end
        points_checked++;
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tilted_face_point_projection test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Send one point; returns at the edge that accepts it
  task automatic send_point(point_t pt);
    logic ready;
    start <= 1'b1;
    point <= pt;
    forever begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
      if (ready) break;
    end
  endtask

  task automatic idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every projection is back, plus the pipeline depth
  task automatic drain();
    start <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  // Write all six registers, one per cycle, while the pipeline is empty
  task automatic write_config(logic [9:0] w, logic [9:0] h, logic [9:0] d,
                              logic [11:0] cx, logic [11:0] cy, logic [15:0] s);
    logic [15:0] vals[6];
    logic [2:0]  idx[6];
    vals = '{16'(w), 16'(h), 16'(d), 16'(cx), 16'(cy), s};
    idx  = '{CFG_HALF_W, CFG_HALF_H, CFG_HALF_D, CFG_CENTER_X, CFG_CENTER_Y, CFG_SCALE};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    half_w = w;
    half_h = h;
    half_d = d;
    center_x = cx;
    center_y = cy;
    scale = s;
    cfg_sets++;
    @(posedge clk);
  endtask

  function automatic point_t make_point(int px, int py, int pz, int face,
                                        int tx, int ty);
    point_t pt;
    pt.point_x = 16'(px);
    pt.point_y = 16'(py);
    pt.point_z = 16'(pz);
    pt.view_face = 3'(face);
    pt.tilt_about_x = 16'(tx);
    pt.tilt_about_y = 16'(ty);
    return pt;
  endfunction

  // Coordinate near the cube, clipped to 16 bits
  function automatic int near_coord(int half);
    int span;
    span = half * 64 + 1200;
    return int'(clip(longint'(int'($urandom_range(0, 2 * span)) - span), 32768));
  endfunction

  function automatic point_t random_point();
    point_t pt;
    int sel;
    int tmax;
    logic [95:0] raw;
    sel = $urandom_range(0, 9);
    tmax = (sel < 5) ? 3000 : 32767;
    if (sel < 8) begin
      pt = make_point(near_coord(half_w), near_coord(half_h), near_coord(half_d),
                      $urandom_range(0, 5),
                      $urandom_range(0, 2 * tmax) - tmax,
                      $urandom_range(0, 2 * tmax) - tmax);
    end else begin
      raw = {$urandom, $urandom, $urandom};
      pt = raw[$bits(point_t)-1:0];
    end
    return pt;
  endfunction

  // Directed corners: every face, unused faces, extremes, walls, behind the eye
  task automatic test_directed();
    for (int f = 0; f < 8; f++) send_point(make_point(640, -320, 960, f, 4000, -4000));
    send_point(make_point(32767, 32767, 32767, FACE_FRONT, 32767, 32767));
    send_point(make_point(-32768, -32768, -32768, FACE_BACK, -32768, -32768));
    send_point(make_point(-32768, 0, 0, FACE_LEFT, 0, 0));
    send_point(make_point(32767, 0, 0, FACE_RIGHT, 0, 0));
    send_point(make_point(0, 32767, 0, FACE_TOP, -32768, 32767));
    send_point(make_point(0, -32768, 0, FACE_BOTTOM, 32767, -32768));
    send_point(make_point(64 * 64 - 1, 48 * 64 - 1, 0, FACE_FRONT, 0, 0));
    send_point(make_point(64 * 64 - 768, -(48 * 64 - 768), 100, FACE_FRONT, 0, 0));
    send_point(make_point(64 * 64 - 767, 48 * 64 - 767, 100, FACE_BOTTOM, 1000, 0));
    send_point(make_point(-(64 * 64 + 500), 48 * 64 + 500, 0, FACE_TOP, 0, 0));
    send_point(make_point(0, 0, 0, FACE_FRONT, 0, 0));
    send_point(make_point(-14080 - 64 * 64, 0, 0, FACE_LEFT, 0, 0));
    send_point(make_point(-14081 - 64 * 64, 10, 5, FACE_LEFT, 0, 0));
    idle(1);
  endtask

  // Random points in bursts with random gaps
  task automatic test_random(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_point(random_point());
        left--;
      end
      if ($urandom_range(0, 4) != 0) idle($urandom_range(1, 12));
    end
    idle(1);
  endtask

  // Register extremes with directed or random points, then random settings, each with a random batch
  task automatic test_config_sweep();
    write_config(10'd1, 10'd1, 10'd1, 12'd0, 12'd0, 16'd1);
    test_directed();
    write_config(10'd1023, 10'd1023, 10'd1023, 12'd4095, 12'd4095, 16'hFFFF);
    test_directed();
    write_config(10'd0, 10'd0, 10'd0, 12'd2048, 12'd1024, 16'd0);
    test_random(20);
    for (int k = 0; k < 4; k++) begin
      write_config(10'($urandom_range(1, 200)), 10'($urandom_range(1, 200)),
                   10'($urandom_range(1, 200)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   16'($urandom_range(1, 65535)));
      test_random(RANDOM_ITEMS / 8);
    end
    write_config(10'd64, 10'd48, 10'd48, 12'd160, 12'd120, 16'd4096);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    point = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HALF_W;
    cfg_data = '0;
    errors = 0;
    points_sent = 0;
    points_checked = 0;
    behind_seen = 0;
    cfg_sets = 0;
    half_w = RST_HALF_W;
    half_h = RST_HALF_H;
    half_d = RST_HALF_D;
    center_x = RST_CENTER_X;
    center_y = RST_CENTER_Y;
    scale = RST_SCALE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(RANDOM_ITEMS / 4);
    test_config_sweep();
    test_random(RANDOM_ITEMS / 8);

    drain();
    $display("Checked %0d of %0d points over %0d register settings,", points_checked,
             points_sent, cfg_sets + 1);
    $display("all six faces, unused faces, wall blends and %0d points behind the eye.",
             behind_seen);
    if (errors == 0) begin
      $display("tilted_face_point_projection test passed");
    end else begin
      $display("tilted_face_point_projection test failed");
    end
    $finish;
  end

endmodule
